// ----- rtl/core/ovl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovl_pkg
// Shared constants for the ordered value list: field widths, request and
// status codes, and the default list depth.
// ----------------------------------------------------------------------------
package ovl_pkg;

   localparam int MAX_ENTRIES_DEF = 16;

   localparam int VALUE_W = 32;
   localparam int MODE_W  = 3;
   localparam int STAT_W  = 2;
   localparam int POS_W   = 4;
   localparam int TOTAL_W = 5;

   localparam int REQ_DATA_W = 2 * VALUE_W;
   localparam int RSP_DATA_W = 16;

   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FIND   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

// ----- rtl/core/ovl_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovl_store
// Entry memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ovl_store
   import ovl_pkg::*;
#(
   parameter int DEPTH  = MAX_ENTRIES_DEF,
   parameter int ADDR_W = $clog2(MAX_ENTRIES_DEF)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ordered_value_list_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_value_list_core
// Bounded ordered list of 32-bit values kept head first in one memory.
// ----------------------------------------------------------------------------
// One request is worked at a time; the next is taken once the result is in
// the output register. Append, clear and unused modes go straight to the
// done state and then load the output register. Find, update and erase scan
// the entry memory from the head, one read per cycle with registered read
// data, until a hit or the tail. Erase then closes up the gap, moving one
// entry per cycle through the same memory. The longest request is an erase
// at the head of a full list. The memory needs no clearing after reset.
module ordered_value_list_core
   import ovl_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // value [31:0], replacement [63:32]
   input  logic [MODE_W-1:0]     req_tuser,  // mode [2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // position [3:0], entry_total [8:4]
   output logic [STAT_W-1:0]     rsp_tuser   // status [1:0]
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [VALUE_W-1:0] nval_ff, nval_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [VALUE_W-1:0] rd_data;

   logic                     req_fire;
   logic                     issue;
   logic                     hit;
   logic                     full;
   logic [CNT_W+IDX_W-1:0]   pend_wide;
   logic [POS_W+IDX_W-1:0]   pos_wide;
   logic [TOTAL_W+CNT_W-1:0] total_wide;

   ovl_store #(
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(MAX_ENTRIES));
   assign issue      = (scan_ff < count_ff);
   assign hit        = pend_ff && (rd_data == key_ff);
   assign pend_wide  = {{CNT_W{1'b0}}, pend_idx_ff};
   assign pos_wide   = {{POS_W{1'b0}}, pos_ff};
   assign total_wide = {{TOTAL_W{1'b0}}, count_ff};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      nval_in       = nval_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      status_in     = status_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_total_in  = rsp_total_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = req_tdata[VALUE_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in  = req_tuser;
               key_in   = req_tdata[VALUE_W-1:0];
               nval_in  = req_tdata[REQ_DATA_W-1:VALUE_W];
               pos_in   = '0;
               state_in = S_DONE;
               case (req_tuser)
                  MODE_APPEND: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        pos_in    = count_ff[IDX_W-1:0];
                        count_in  = count_ff + CNT_W'(1);
                        status_in = ST_OK;
                     end
                  end
                  MODE_FIND, MODE_UPDATE, MODE_ERASE: begin
                     scan_in  = '0;
                     pend_in  = 1'b0;
                     state_in = S_SCAN;
                  end
                  MODE_CLEAR: begin
                     count_in  = '0;
                     status_in = ST_OK;
                  end
                  default: begin
                     status_in = ST_MISS;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               status_in = ST_OK;
               pos_in    = pend_idx_ff;
               pend_in   = 1'b0;
               state_in  = S_DONE;
               if (mode_ff == MODE_UPDATE) begin
                  wr_en   = 1'b1;
                  wr_addr = pend_idx_ff;
                  wr_data = nval_ff;
               end else if (mode_ff == MODE_ERASE) begin
                  // start moving entries up from just behind the match
                  scan_in  = pend_wide[CNT_W-1:0] + CNT_W'(1);
                  state_in = S_SHIFT;
               end
            end else if (issue) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + CNT_W'(1);
            end else begin
               status_in = ST_MISS;
               pos_in    = '0;
               pend_in   = 1'b0;
               state_in  = S_DONE;
            end
         end
         S_SHIFT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - IDX_W'(1);
               wr_data = rd_data;
            end
            if (issue) begin
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[IDX_W-1:0];
               scan_in     = scan_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            // load the output word once the previous one is gone
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pos_in    = pos_wide[POS_W-1:0];
               rsp_total_in  = total_wide[TOTAL_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      nval_ff       <= nval_in;
      scan_ff       <= scan_in;
      pend_idx_ff   <= pend_idx_in;
      status_ff     <= status_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-POS_W-TOTAL_W){1'b0}}, rsp_total_ff, rsp_pos_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above list depth");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == MODE_CLEAR) |=> (count_ff == '0))
      else $error("clear left entries behind");

   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && wr_en) |-> ({1'b0, wr_addr} < {1'b0, count_ff}))
      else $error("compaction wrote beyond the list");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK || rsp_tuser == ST_MISS || rsp_tuser == ST_FULL))
      else $error("bad status code");

endmodule
